// ----- hw/rtl/vtm_pkg.sv -----
// package for the virtual timer multiplexer
// holds function codes, word types and shared constants; no dependencies
package vtm_pkg;

    localparam int FUNC_W = 3;
    localparam int SLOT_W = 4;
    localparam int FIELD_W = 32;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W = 1;
    localparam int TIU_W = 5;
    localparam int MARGIN_W = 16;
    localparam int MAX_RESULTS = 16;

    typedef enum logic [FUNC_W-1:0] {
        FN_DEFINE = 3'd0,
        FN_CHANGE = 3'd1,
        FN_START  = 3'd2,
        FN_STOP   = 3'd3,
        FN_ELAPSE = 3'd4
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMERS_IN_USE = 1'd0,
        CFG_EARLY_MARGIN  = 1'd1
    } t_cfg_idx;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [SLOT_W-1:0]  slot;
        logic [FIELD_W-1:0] delay_ticks;
        logic [FIELD_W-1:0] period_ticks;
        logic               single_shot;
        logic [FIELD_W-1:0] elapsed_ticks;
    } t_in_word;

    typedef struct packed {
        logic               accepted;
        logic               fired;
        logic [SLOT_W-1:0]  fired_slot;
        logic               any_running;
        logic [FIELD_W-1:0] next_compare;
        logic               last;
    } t_out_word;

endpackage

// ----- hw/rtl/vtm_in_if.sv -----
// input channel interface: valid, ready and input word
// depends on vtm_pkg
interface vtm_in_if;
    logic              valid;
    logic              ready;
    vtm_pkg::t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/vtm_out_if.sv -----
// output channel interface: valid, ready and result word
// depends on vtm_pkg
interface vtm_out_if;
    logic               valid;
    logic               ready;
    vtm_pkg::t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/vtm_queue.sv -----
// two-entry queue that decouples the front end from the timer engine
// depends on vtm_pkg
module vtm_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  vtm_pkg::t_in_word i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output vtm_pkg::t_in_word o_data
);
    vtm_pkg::t_in_word r_mem [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

// ----- hw/rtl/vtm_engine.sv -----
// timer engine: slot table, elapse scan, summary scan and result emission
// depends on vtm_pkg
module vtm_engine #(
    parameter int NUM_TIMERS = 16,
    parameter int TICK_BITS  = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [vtm_pkg::TIU_W-1:0]      i_timers_in_use,
    input  logic [vtm_pkg::MARGIN_W-1:0]   i_margin,
    input  logic                           i_valid,
    input  vtm_pkg::t_in_word              i_data,
    output logic                           o_pop,
    output logic                           o_valid,
    output vtm_pkg::t_out_word             o_data,
    input  logic                           i_ready
);
    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W = $clog2(NUM_TIMERS + 1);
    localparam int REM_W = TICK_BITS + 2;
    localparam int FW = vtm_pkg::FIELD_W;

    typedef enum logic [2:0] {
        S_IDLE, S_ELAPSE, S_SUM, S_EMIT, S_LIST
    } t_state;

    logic [TICK_BITS-1:0] r_period [NUM_TIMERS];
    logic [TICK_BITS-1:0] r_delay  [NUM_TIMERS];
    logic signed [REM_W-1:0] r_rem [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] r_oneshot, r_run, r_def;
    logic [IDX_W-1:0] r_fl [NUM_TIMERS];

    t_state r_state;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_nf;
    logic [CNT_W-1:0] r_ok;
    logic r_acc, r_elapse, r_found;
    logic signed [REM_W-1:0] r_least;
    logic [TICK_BITS-1:0] r_elapsed;
    logic r_ov;
    vtm_pkg::t_out_word r_out;

    logic [IDX_W-1:0] w_i;
    logic signed [REM_W-1:0] w_sub;
    logic signed [REM_W-1:0] w_reload;
    logic [vtm_pkg::SLOT_W-1:0] w_slot;
    logic [IDX_W-1:0] w_si;
    logic w_in_rng;
    logic [CNT_W-1:0] w_limit;
    logic [FW-1:0] w_next;
    logic [TICK_BITS-1:0] w_dly, w_per;
    logic w_acc;
    logic w_emit;

    assign w_i = r_idx[IDX_W-1:0];
    assign w_sub = r_rem[w_i] - REM_W'(r_elapsed);
    assign w_reload = REM_W'(r_period[w_i]) + REM_W'(r_delay[w_i]);
    assign w_slot = i_data.slot;
    assign w_si = IDX_W'(w_slot);
    assign w_in_rng = (32'(w_slot) < NUM_TIMERS);
    assign w_limit = (32'(i_timers_in_use) < NUM_TIMERS) ?
                     CNT_W'(i_timers_in_use) : CNT_W'(NUM_TIMERS);
    assign w_dly = TICK_BITS'(i_data.delay_ticks);
    assign w_per = TICK_BITS'(i_data.period_ticks);
    assign w_emit = ((r_state == S_EMIT) || (r_state == S_LIST)) && (!r_ov || i_ready);

    always_comb begin
        w_acc = 1'b0;
        if (i_data.func == vtm_pkg::FN_ELAPSE) begin
            w_acc = 1'b1;
        end else if (w_in_rng) begin
            case (i_data.func) inside
                vtm_pkg::FN_DEFINE: w_acc = (CNT_W'(w_slot) < w_limit);
                vtm_pkg::FN_CHANGE, vtm_pkg::FN_START, vtm_pkg::FN_STOP: w_acc = r_def[w_si];
                default: w_acc = 1'b0;
            endcase
        end
    end

    always_comb begin
        if (!r_found || r_least < 0) begin
            w_next = '0;
        end else if (r_least > REM_W'(64'hFFFF_FFFF)) begin
            w_next = '1;
        end else begin
            w_next = FW'(r_least);
        end
    end

    assign o_pop   = (r_state == S_IDLE) && i_valid;
    assign o_valid = r_ov;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_run     <= '0;
            r_oneshot <= '0;
            r_def     <= '0;
            r_ov      <= 1'b0;
            r_idx     <= '0;
            r_nf      <= '0;
        end else begin
            if (w_emit) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_idx     <= '0;
                        r_nf      <= '0;
                        r_found   <= 1'b0;
                        r_least   <= '0;
                        r_elapsed <= TICK_BITS'(i_data.elapsed_ticks);
                        r_elapse  <= (i_data.func == vtm_pkg::FN_ELAPSE);
                        r_acc     <= w_acc;
                        if (i_data.func == vtm_pkg::FN_ELAPSE) begin
                            r_state <= S_ELAPSE;
                        end else begin
                            r_state <= S_SUM;
                            if (w_in_rng) begin
                                case (i_data.func)
                                    vtm_pkg::FN_DEFINE: begin
                                        if (CNT_W'(w_slot) < w_limit) begin
                                            r_period[w_si]  <= w_per;
                                            r_delay[w_si]   <= w_dly;
                                            r_oneshot[w_si] <= i_data.single_shot;
                                            r_run[w_si]     <= 1'b0;
                                            r_rem[w_si] <= REM_W'(w_per) + REM_W'(w_dly);
                                            r_def[w_si]     <= 1'b1;
                                        end
                                    end
                                    vtm_pkg::FN_CHANGE: begin
                                        if (r_def[w_si]) begin
                                            r_period[w_si]  <= w_per;
                                            r_delay[w_si]   <= w_dly;
                                            r_oneshot[w_si] <= i_data.single_shot;
                                        end
                                    end
                                    vtm_pkg::FN_START: begin
                                        if (r_def[w_si]) begin
                                            if (!r_run[w_si]) begin
                                                r_run[w_si] <= 1'b1;
                                                r_rem[w_si] <= REM_W'(r_period[w_si])
                                                             + REM_W'(r_delay[w_si]);
                                            end
                                        end
                                    end
                                    vtm_pkg::FN_STOP: begin
                                        if (r_def[w_si]) begin
                                            r_run[w_si] <= 1'b0;
                                        end
                                    end
                                    default: begin
                                    end
                                endcase
                            end
                        end
                    end
                end
                S_ELAPSE: begin
                    if (r_run[w_i]) begin
                        if (w_sub <= $signed({2'b00, 16'(i_margin)})) begin
                            if (r_nf < CNT_W'(NUM_TIMERS)) begin
                                r_fl[r_nf[IDX_W-1:0]] <= w_i;
                            end
                            r_nf <= r_nf + 1'b1;
                            if (r_oneshot[w_i]) begin
                                r_run[w_i] <= 1'b0;
                                r_rem[w_i] <= w_sub;
                            end else begin
                                r_rem[w_i] <= w_reload;
                            end
                        end else begin
                            r_rem[w_i] <= w_sub;
                        end
                    end
                    if (r_idx == CNT_W'(NUM_TIMERS - 1)) begin
                        r_idx   <= '0;
                        r_state <= S_SUM;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_SUM: begin
                    if (r_run[w_i] && (!r_found || r_rem[w_i] < r_least)) begin
                        r_least <= r_rem[w_i];
                        r_found <= 1'b1;
                    end
                    if (r_idx == CNT_W'(NUM_TIMERS - 1)) begin
                        r_idx   <= '0;
                        r_ok    <= (r_nf > CNT_W'(vtm_pkg::MAX_RESULTS)) ?
                                   CNT_W'(vtm_pkg::MAX_RESULTS) : r_nf;
                        r_state <= (r_elapse && r_nf != '0) ? S_LIST : S_EMIT;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (w_emit) begin
                        r_out.accepted    <= r_acc;
                        r_out.fired       <= 1'b0;
                        r_out.fired_slot  <= '0;
                        r_out.any_running <= r_found;
                        r_out.next_compare <= w_next;
                        r_out.last        <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_LIST: begin
                    if (w_emit) begin
                        r_out.accepted    <= 1'b1;
                        r_out.fired       <= 1'b1;
                        r_out.fired_slot  <= vtm_pkg::SLOT_W'(r_fl[w_i]);
                        r_out.any_running <= r_found;
                        r_out.next_compare <= w_next;
                        r_out.last        <= (r_idx + 1'b1 == r_ok);
                        r_idx <= r_idx + 1'b1;
                        if (r_idx + 1'b1 == r_ok) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- hw/rtl/virtual_timer_multiplexer.sv -----
// define/change/start/stop run a slot update, a summary scan and one result;
// elapse runs an elapse scan, a summary scan and a result per reported firing;
// one item at a time, set by one-slot-per-cycle update and minimum table scans
// reset: all timers undefined and stopped, timers_in_use 16, margin 1500
module virtual_timer_multiplexer #(
    parameter int NUM_TIMERS = 16,
    parameter int TICK_BITS  = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    vtm_in_if.sink                             in_ch,
    vtm_out_if.source                          out_ch,
    input  logic                               i_cfg_we,
    input  logic [vtm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [vtm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    logic [vtm_pkg::TIU_W-1:0]    r_tiu;
    logic [vtm_pkg::MARGIN_W-1:0] r_margin;
    logic q_full, q_valid, q_pop;
    vtm_pkg::t_in_word q_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tiu    <= vtm_pkg::TIU_W'(16);
            r_margin <= vtm_pkg::MARGIN_W'(1500);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vtm_pkg::CFG_TIMERS_IN_USE: r_tiu <= i_cfg_data[vtm_pkg::TIU_W-1:0];
                vtm_pkg::CFG_EARLY_MARGIN:  r_margin <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign in_ch.ready = !q_full;

    vtm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_ch.valid && !q_full),
        .i_data  (in_ch.data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    vtm_engine #(
        .NUM_TIMERS (NUM_TIMERS),
        .TICK_BITS  (TICK_BITS)
    ) u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_timers_in_use (r_tiu),
        .i_margin        (r_margin),
        .i_valid         (q_valid),
        .i_data          (q_data),
        .o_pop           (q_pop),
        .o_valid         (out_ch.valid),
        .o_data          (out_ch.data),
        .i_ready         (out_ch.ready)
    );
endmodule
